[hw/rtl/lspp_pkg.sv]
`timescale 1ns / 1ps
// Package for the looped sample playback pointer core.
// Holds the sizes, register indexes, codes and state type; depends on nothing.
package lspp_pkg;

  localparam int ADDR_BITS    = 20;
  localparam int MAX_SEGMENTS = 64;

  localparam int SEG_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int WORK_W  = 30;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef logic signed [WORK_W-1:0] work_t;

  localparam work_t WORK_ZERO     = work_t'(0);
  localparam work_t POS_MAX_W     = work_t'(2097151);
  localparam work_t POS_MIN_W     = work_t'(-2097152);
  localparam work_t COUNT_MAX_W   = work_t'(8191);
  localparam logic [19:0] SEG_ADDR_MASK = 20'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [2:0] REG_SAMPLE_LENGTH = 3'd0;
  localparam logic [2:0] REG_LOOP_BEGIN    = 3'd1;
  localparam logic [2:0] REG_LOOP_FINISH   = 3'd2;
  localparam logic [2:0] REG_INITIAL_LOOPS = 3'd3;
  localparam logic [2:0] REG_FRAME_LENGTH  = 3'd4;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_FIN,
    S_FETCH,
    S_SINGLE
  } lspp_state_t;

endpackage

[hw/rtl/looped_sample_playback_pointer_core.sv]
`timescale 1ns / 1ps
// Voice address generator for looped sample playback, single module.
// Depends on lspp_pkg for sizes, register indexes and the state type.
//
// A start word loads the play position and loop counter and gives no result
// word. A frame word gives one or more result words (fetch segments), the
// final one flagged by out_last with out_stopped and out_overflow valid on it.
// in_stall stays high while a frame is worked on, so a new frame word is taken
// only once the last one is through its work. A frame first runs the position
// advance, one pass of the shared wrap adder per cycle (1 to MAX_SEGMENTS
// passes), then a finishing step, then emits one segment per cycle while the
// output slot is free (1 to MAX_SEGMENTS) through the same adder; if the
// finishing step finds nothing to fetch, one empty last word goes out instead.
// Stopped, suspended and kill frames skip the advance and give only such a word.
// Results sit in an output register, so a stall on out_stall only holds the
// result phase, and the next word may be accepted while the last result
// still waits. Reset is synchronous: the voice comes up stopped, position and
// loop count zero, frame length 512. Configuration is written via the cfg_ port
// by the user only while no frame is in work; the core does not enforce it.
module looped_sample_playback_pointer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic signed [20:0]             in_start_offset,
  input  logic                           in_stop_request,
  input  logic                           in_suspend,
  input  logic                           in_fade,
  input  logic                           in_kill,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [19:0]                    out_seg_start,
  output logic [12:0]                    out_seg_count,
  output logic [11:0]                    out_buffer_offset,
  output logic                           out_last,
  output logic                           out_stopped,
  output logic                           out_overflow,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lspp_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [lspp_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [lspp_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import lspp_pkg::*;

  logic [20:0]        sample_len_r;
  logic [19:0]        loop_begin_r;
  logic [20:0]        loop_finish_r;
  logic [15:0]        init_loops_r;
  logic [12:0]        frame_len_r;
  logic               cfg_wr;

  lspp_state_t        state_r, state_nxt;
  logic signed [21:0] pp_r, pp_nxt;
  logic signed [15:0] ll_r, ll_nxt;
  logic signed [15:0] lc_r, lc_nxt;
  logic               stopped_r, stopped_nxt;
  work_t              work_pos_r, work_pos_nxt;
  work_t              work_cnt_r, work_cnt_nxt;
  logic [11:0]        off_r, off_nxt;
  logic [SEG_W-1:0]   pass_r, pass_nxt;
  logic [SEG_W-1:0]   seg_r, seg_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [19:0]        out_start_r, out_start_nxt;
  logic [12:0]        out_count_r, out_count_nxt;
  logic [11:0]        out_off_r, out_off_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_stop_r, out_stop_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               in_acc;
  logic               slot_free;
  logic               stop_now;
  work_t              lf_w, lb_w, len_w, fl_w, pp_w;

  // Shared wrap adder.
  logic signed [15:0] unit_lc, unit_lc_dec;
  work_t              unit_sum, unit_rem, unit_head;
  logic               unit_wrap;

  work_t              adv_pos, adv_cnt;
  logic               adv_done;

  work_t              pos_sat, pp_plus_fl, neg_pp;
  logic               stop_fin, fetch_go;

  work_t              seg_cnt_pre, seg_end, seg_cnt_cut, seg_cnt, seg_rem;
  logic               seg_cut, seg_cap, seg_last, seg_ovf;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[4:2])
      REG_SAMPLE_LENGTH: cfg_prdata = PDATA_W'(sample_len_r);
      REG_LOOP_BEGIN:    cfg_prdata = PDATA_W'(loop_begin_r);
      REG_LOOP_FINISH:   cfg_prdata = PDATA_W'(loop_finish_r);
      REG_INITIAL_LOOPS: cfg_prdata = PDATA_W'(init_loops_r);
      REG_FRAME_LENGTH:  cfg_prdata = PDATA_W'(frame_len_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_len_r  <= '0;
      loop_begin_r  <= '0;
      loop_finish_r <= '0;
      init_loops_r  <= '0;
      frame_len_r   <= 13'd512;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_SAMPLE_LENGTH: sample_len_r  <= cfg_pwdata[20:0];
        REG_LOOP_BEGIN:    loop_begin_r  <= cfg_pwdata[19:0];
        REG_LOOP_FINISH:   loop_finish_r <= cfg_pwdata[20:0];
        REG_INITIAL_LOOPS: init_loops_r  <= cfg_pwdata[15:0];
        REG_FRAME_LENGTH:  frame_len_r   <= cfg_pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign slot_free = ~out_valid_r | ~out_stall;
  assign stop_now  = stopped_r | in_stop_request | in_kill;

  assign lf_w  = $signed(WORK_W'(loop_finish_r));
  assign lb_w  = $signed(WORK_W'(loop_begin_r));
  assign len_w = $signed(WORK_W'(sample_len_r));
  assign fl_w  = $signed(WORK_W'(frame_len_r));
  assign pp_w  = WORK_W'(pp_r);

  always_comb begin
    unit_lc     = (state_r == S_FETCH) ? lc_r : ll_r;
    unit_sum    = work_pos_r + work_cnt_r;
    unit_rem    = unit_sum - lf_w;
    unit_head   = lf_w - work_pos_r;
    unit_wrap   = (unit_lc != 16'sd0) && (unit_rem > WORK_ZERO);
    unit_lc_dec = (unit_wrap && (unit_lc > 16'sd0)) ? unit_lc - 16'sd1 : unit_lc;
  end

  always_comb begin
    adv_pos  = unit_wrap ? lb_w + unit_head : unit_sum;
    adv_cnt  = unit_wrap ? unit_rem : WORK_ZERO;
    adv_done = (adv_cnt == WORK_ZERO) || (pass_r == SEG_W'(MAX_SEGMENTS - 1));
  end

  always_comb begin
    if (work_pos_r > POS_MAX_W) begin
      pos_sat = POS_MAX_W;
    end else if (work_pos_r < POS_MIN_W) begin
      pos_sat = POS_MIN_W;
    end else begin
      pos_sat = work_pos_r;
    end
    stop_fin   = (ll_r == 16'sd0) && (pos_sat >= len_w);
    pp_plus_fl = pp_w + fl_w;
    neg_pp     = WORK_ZERO - pp_w;
    fetch_go   = pp_plus_fl > WORK_ZERO;
  end

  always_comb begin
    seg_cnt_pre = unit_wrap ? unit_head : work_cnt_r;
    seg_end     = unit_wrap ? lf_w : unit_sum;
    seg_cut     = seg_end > len_w;
    seg_cnt_cut = seg_cut ? len_w - work_pos_r : seg_cnt_pre;
    seg_cnt     = (seg_cnt_cut < WORK_ZERO) ? WORK_ZERO : seg_cnt_cut;
    seg_rem     = (unit_wrap && !seg_cut) ? unit_rem : WORK_ZERO;
    seg_cap     = (seg_r == SEG_W'(MAX_SEGMENTS - 1));
    seg_last    = (seg_rem == WORK_ZERO) || seg_cap;
    seg_ovf     = (seg_rem != WORK_ZERO) && seg_cap;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_action == ACT_FRAME)) begin
          state_nxt = (stop_now || in_suspend) ? S_SINGLE : S_ADV;
        end
      end
      S_ADV: begin
        if (adv_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = fetch_go ? S_FETCH : S_SINGLE;
      end
      S_FETCH: begin
        if (slot_free && seg_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pp_nxt        = pp_r;
    ll_nxt        = ll_r;
    lc_nxt        = lc_r;
    stopped_nxt   = stopped_r;
    work_pos_nxt  = work_pos_r;
    work_cnt_nxt  = work_cnt_r;
    off_nxt       = off_r;
    pass_nxt      = pass_r;
    seg_nxt       = seg_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_start_nxt = out_start_r;
    out_count_nxt = out_count_r;
    out_off_nxt   = out_off_r;
    out_last_nxt  = out_last_r;
    out_stop_nxt  = out_stop_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_action == ACT_START)) begin
          pp_nxt      = 22'(in_start_offset);
          ll_nxt      = ({1'b0, loop_begin_r} == loop_finish_r) ? 16'sd0
                                                                : $signed(init_loops_r);
          stopped_nxt = 1'b0;
        end else if (in_acc) begin
          if (stop_now) begin
            stopped_nxt = 1'b1;
          end else if (!in_suspend) begin
            ll_nxt       = in_fade ? 16'sd0 : ll_r;
            lc_nxt       = in_fade ? 16'sd0 : ll_r;
            work_pos_nxt = pp_w;
            work_cnt_nxt = fl_w;
            pass_nxt     = '0;
          end
        end
      end
      S_ADV: begin
        ll_nxt       = unit_lc_dec;
        work_pos_nxt = adv_pos;
        work_cnt_nxt = adv_cnt;
        pass_nxt     = pass_r + SEG_W'(1);
      end
      S_FIN: begin
        pp_nxt       = pos_sat[21:0];
        stopped_nxt  = stop_fin;
        work_pos_nxt = (pp_r < 22'sd0) ? WORK_ZERO : pp_w;
        work_cnt_nxt = (pp_r < 22'sd0) ? pp_plus_fl : fl_w;
        off_nxt      = (pp_r < 22'sd0) ? neg_pp[11:0] : 12'd0;
        seg_nxt      = '0;
      end
      S_FETCH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_start_nxt = work_pos_r[19:0] & SEG_ADDR_MASK;
          out_count_nxt = (seg_cnt > COUNT_MAX_W) ? 13'h1FFF : seg_cnt[12:0];
          out_off_nxt   = off_r;
          out_last_nxt  = seg_last;
          out_stop_nxt  = seg_last & stopped_r;
          out_ovf_nxt   = seg_ovf;
          off_nxt       = off_r + seg_cnt[11:0];
          work_pos_nxt  = unit_wrap ? lb_w : work_pos_r;
          work_cnt_nxt  = seg_rem;
          lc_nxt        = unit_lc_dec;
          seg_nxt       = seg_r + SEG_W'(1);
        end
      end
      S_SINGLE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_start_nxt = '0;
          out_count_nxt = '0;
          out_off_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_stop_nxt  = stopped_r;
          out_ovf_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pp_r        <= '0;
      ll_r        <= '0;
      stopped_r   <= 1'b1;
      out_valid_r <= 1'b0;
      pass_r      <= '0;
      seg_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pp_r        <= pp_nxt;
      ll_r        <= ll_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
      seg_r       <= seg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lc_r        <= lc_nxt;
    work_pos_r  <= work_pos_nxt;
    work_cnt_r  <= work_cnt_nxt;
    off_r       <= off_nxt;
    out_start_r <= out_start_nxt;
    out_count_r <= out_count_nxt;
    out_off_r   <= out_off_nxt;
    out_last_r  <= out_last_nxt;
    out_stop_r  <= out_stop_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_seg_start     = out_start_r;
  assign out_seg_count     = out_count_r;
  assign out_buffer_offset = out_off_r;
  assign out_last          = out_last_r;
  assign out_stopped       = out_stop_r;
  assign out_overflow      = out_ovf_r;

  a_start_revives: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == ACT_START)) |=> !stopped_r)
    else $error("start word did not revive the voice");

  a_flags_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_ovf_r || out_stop_r)) |-> out_last_r)
    else $error("stopped or overflow flag on a word that is not last");

  a_fin_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> ((state_r == S_FETCH) || (state_r == S_SINGLE)))
    else $error("finishing cycle not followed by result phase");

  a_kill_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == ACT_FRAME) && (in_kill || in_stop_request))
      |=> (stopped_r && (state_r == S_SINGLE)))
    else $error("kill or stop request did not stop the voice");

endmodule
